/* sv/bed_pkg.sv */
`timescale 1ns / 1ps

package bed_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       final_out;
  } out_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_ESCAPE = 8'h1B;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // decoder state carried between bytes
  typedef struct packed {
    mode_t      mode;
    logic [7:0] value;
    logic [1:0] count;
  } state_t;

  // what one request produces: up to two bytes and the next state
  typedef struct packed {
    logic [1:0] num;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;
    state_t     nxt;
  } dec_t;

endpackage

/* sv/backslash_escape_decoder.sv */
`timescale 1ns / 1ps

// Channel  Signals                      Carries
// raw      raw_valid, raw_stall, raw    escaped byte plus end-of-text flag
// dec      dec_valid, dec_stall, dec    decoded byte plus final flag
//
// One request per cycle while raw_stall is low; the decode is combinational into a two-byte result buffer.
// A request that yields two bytes holds raw_stall high until the first
// of the two bytes has been taken from the buffer.
// dec_stall stalls raw only while a byte waits in the result buffer.
// rst (synchronous) returns the decoder to plain text and empties the buffer.

module backslash_escape_decoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          raw_valid,
  output logic          raw_stall,
  input  bed_pkg::in_t  raw,
  output logic          dec_valid,
  input  logic          dec_stall,
  output bed_pkg::out_t dec
);

  bed_pkg::state_t state;
  bed_pkg::dec_t   res;
  bed_pkg::out_t   slot0;
  bed_pkg::out_t   slot1;
  logic            v0;
  logic            v1;
  logic            take;
  logic            drain;

  bed_decode u_decode (
    .cur (state),
    .raw (raw),
    .res (res)
  );

  assign raw_stall = v0 && (dec_stall || v1);
  assign take      = raw_valid && !raw_stall;
  assign drain     = v0 && !dec_stall;
  assign dec_valid = v0;
  assign dec       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
    end else if (take) begin
      state <= res.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (take) begin
      v0 <= (res.num != 2'd0);
      v1 <= (res.num == 2'd2);
    end else if (drain) begin
      // advance the second byte
      v0 <= v1;
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot0.char_out  <= res.byte0;
      slot0.final_out <= res.last && (res.num == 2'd1);
      slot1.char_out  <= res.byte1;
      slot1.final_out <= res.last;
    end else if (drain) begin
      slot0 <= slot1;
    end
  end

endmodule

/* sv/bed_decode.sv */
`timescale 1ns / 1ps

module bed_decode (
  input  bed_pkg::state_t cur,
  input  bed_pkg::in_t    raw,
  output bed_pkg::dec_t   res
);

  logic [7:0] c;
  logic       is_oct;
  logic [3:0] hex_val;
  logic       is_hex;
  logic       known;
  logic [7:0] mapped;

  function automatic bed_pkg::dec_t push(bed_pkg::dec_t d, logic [7:0] v);
    bed_pkg::dec_t r;
    r = d;
    if (d.num == 2'd0) begin
      r.byte0 = v;
    end else begin
      r.byte1 = v;
    end
    r.num = d.num + 2'd1;
    return r;
  endfunction

  assign c      = raw.char_in;
  assign is_oct = (c >= bed_pkg::CH_ZERO) && (c <= bed_pkg::CH_SEVEN);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if ((c >= bed_pkg::CH_ZERO) && (c <= bed_pkg::CH_NINE)) begin
      hex_val = c[3:0];
    end else if (((c >= bed_pkg::CH_LC_A) && (c <= bed_pkg::CH_LC_F)) ||
                 ((c >= bed_pkg::CH_UC_A) && (c <= bed_pkg::CH_UC_F))) begin
      // letters a..f and A..F share their low three bits
      hex_val = 4'd9 + {1'b0, c[2:0]};
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    known  = 1'b1;
    mapped = c;
    case (c)
      8'h61:   mapped = 8'h07;             // a
      8'h62:   mapped = 8'h08;             // b
      8'h65:   mapped = bed_pkg::CH_ESCAPE; // e
      8'h66:   mapped = 8'h0C;             // f
      8'h6E:   mapped = 8'h0A;             // n
      8'h72:   mapped = 8'h0D;             // r
      8'h74:   mapped = 8'h09;             // t
      8'h76:   mapped = 8'h0B;             // v
      bed_pkg::CH_BSLASH, bed_pkg::CH_SQUOTE, bed_pkg::CH_DQUOTE: mapped = c;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    logic plain_after;
    res          = '0;
    res.nxt      = cur;
    res.last     = raw.end_of_text;
    plain_after  = 1'b0;

    unique case (cur.mode)
      bed_pkg::MODE_PLAIN: begin
        plain_after = 1'b1;
      end
      bed_pkg::MODE_ESC: begin
        if (known) begin
          res          = push(res, mapped);
          res.nxt.mode = bed_pkg::MODE_PLAIN;
        end else if (is_oct) begin
          res.nxt.mode  = bed_pkg::MODE_OCT;
          res.nxt.value = {5'd0, c[2:0]};
          res.nxt.count = 2'd1;
        end else if (c == bed_pkg::CH_LC_X) begin
          res.nxt.mode  = bed_pkg::MODE_HEX;
          res.nxt.value = 8'd0;
          res.nxt.count = 2'd0;
        end else begin
          // unknown escape: hand back the backslash, then the byte as text
          res          = push(res, bed_pkg::CH_BSLASH);
          res.nxt.mode = bed_pkg::MODE_PLAIN;
          plain_after  = 1'b1;
        end
      end
      bed_pkg::MODE_OCT: begin
        if (is_oct && (cur.count < bed_pkg::OCT_DIGITS)) begin
          res.nxt.value = {cur.value[4:0], c[2:0]};
          res.nxt.count = cur.count + 2'd1;
          if (res.nxt.count >= bed_pkg::OCT_DIGITS) begin
            res     = push(res, res.nxt.value);
            res.nxt = '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
          end
        end else begin
          res         = push(res, cur.value);
          res.nxt     = '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
          plain_after = 1'b1;
        end
      end
      bed_pkg::MODE_HEX: begin
        if (is_hex && (cur.count < bed_pkg::HEX_DIGITS)) begin
          res.nxt.value = {cur.value[3:0], hex_val};
          res.nxt.count = cur.count + 2'd1;
          if (res.nxt.count >= bed_pkg::HEX_DIGITS) begin
            res     = push(res, res.nxt.value);
            res.nxt = '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
          end
        end else begin
          res         = push(res, cur.value);
          res.nxt     = '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
          plain_after = 1'b1;
        end
      end
      default: begin
        res.nxt.mode = bed_pkg::MODE_PLAIN;
      end
    endcase

    if (plain_after) begin
      if (c == bed_pkg::CH_BSLASH) begin
        res.nxt.mode = bed_pkg::MODE_ESC;
      end else begin
        res = push(res, c);
      end
    end

    // flush whatever is pending at end of string
    if (raw.end_of_text) begin
      if (res.nxt.mode == bed_pkg::MODE_ESC) begin
        res = push(res, bed_pkg::CH_BSLASH);
      end else if ((res.nxt.mode == bed_pkg::MODE_OCT) ||
                   (res.nxt.mode == bed_pkg::MODE_HEX)) begin
        res = push(res, res.nxt.value);
      end
      res.nxt = '{mode: bed_pkg::MODE_PLAIN, value: 8'd0, count: 2'd0};
    end
  end

endmodule

/* sim/backslash_escape_decoder_test.sv */
`timescale 1ns / 1ps

module backslash_escape_decoder_test;

  class escape_scoreboard;
    bed_pkg::mode_t mode;
    logic [7:0]     value;
    logic [1:0]     count;
    bed_pkg::out_t  expected_bytes[$];
    int             errors;

    function new();
      mode   = bed_pkg::MODE_PLAIN;
      value  = '0;
      count  = '0;
      errors = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      bed_pkg::out_t o;
      o.char_out  = b;
      o.final_out = 1'b0;
      expected_bytes.push_back(o);
    endfunction

    function void clear_numeric();
      mode  = bed_pkg::MODE_PLAIN;
      value = '0;
      count = '0;
    endfunction

    function void take_plain(logic [7:0] c);
      if (c == bed_pkg::CH_BSLASH) mode = bed_pkg::MODE_ESC;
      else push_byte(c);
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= bed_pkg::CH_ZERO && c <= bed_pkg::CH_NINE)
        return int'(c - bed_pkg::CH_ZERO);
      if (c >= bed_pkg::CH_LC_A && c <= bed_pkg::CH_LC_F)
        return int'(c - bed_pkg::CH_LC_A) + 10;
      if (c >= bed_pkg::CH_UC_A && c <= bed_pkg::CH_UC_F)
        return int'(c - bed_pkg::CH_UC_A) + 10;
      return -1;
    endfunction

    // Work out the decoded bytes caused by one accepted request.
    function void decode_request(bed_pkg::in_t req);
      logic [7:0]    c;
      logic [7:0]    mapped;
      logic          known;
      int            h;
      int            start_size;
      bed_pkg::out_t tail;
      c          = req.char_in;
      start_size = expected_bytes.size();
      case (mode)
        bed_pkg::MODE_PLAIN: take_plain(c);
        bed_pkg::MODE_ESC: begin
          known = 1'b1;
          mapped = '0;
          case (c)
            "a":                mapped = 8'h07;
            "b":                mapped = 8'h08;
            "e":                mapped = bed_pkg::CH_ESCAPE;
            "f":                mapped = 8'h0C;
            "n":                mapped = 8'h0A;
            "r":                mapped = 8'h0D;
            "t":                mapped = 8'h09;
            "v":                mapped = 8'h0B;
            bed_pkg::CH_BSLASH: mapped = bed_pkg::CH_BSLASH;
            bed_pkg::CH_SQUOTE: mapped = bed_pkg::CH_SQUOTE;
            bed_pkg::CH_DQUOTE: mapped = bed_pkg::CH_DQUOTE;
            default:            known = 1'b0;
          endcase
          if (known) begin
            push_byte(mapped);
            mode = bed_pkg::MODE_PLAIN;
          end else if (c >= bed_pkg::CH_ZERO && c <= bed_pkg::CH_SEVEN) begin
            mode  = bed_pkg::MODE_OCT;
            value = c - bed_pkg::CH_ZERO;
            count = 2'd1;
          end else if (c == bed_pkg::CH_LC_X) begin
            mode  = bed_pkg::MODE_HEX;
            value = '0;
            count = '0;
          end else begin
            // unknown escape: emit the backslash, then treat the byte as text
            push_byte(bed_pkg::CH_BSLASH);
            mode = bed_pkg::MODE_PLAIN;
            take_plain(c);
          end
        end
        bed_pkg::MODE_OCT: begin
          if (c >= bed_pkg::CH_ZERO && c <= bed_pkg::CH_SEVEN &&
              count < bed_pkg::OCT_DIGITS) begin
            value = {value[4:0], c[2:0]};
            count = count + 2'd1;
            if (count >= bed_pkg::OCT_DIGITS) begin
              push_byte(value);
              clear_numeric();
            end
          end else begin
            push_byte(value);
            clear_numeric();
            take_plain(c);
          end
        end
        default: begin
          h = hex_digit(c);
          if (h >= 0 && count < bed_pkg::HEX_DIGITS) begin
            value = {value[3:0], h[3:0]};
            count = count + 2'd1;
            if (count >= bed_pkg::HEX_DIGITS) begin
              push_byte(value);
              clear_numeric();
            end
          end else begin
            push_byte(value);
            clear_numeric();
            take_plain(c);
          end
        end
      endcase
      if (req.end_of_text) begin
        // flush whatever escape is still open
        if (mode == bed_pkg::MODE_ESC) push_byte(bed_pkg::CH_BSLASH);
        else if (mode == bed_pkg::MODE_OCT || mode == bed_pkg::MODE_HEX) push_byte(value);
        clear_numeric();
        if (expected_bytes.size() > start_size) begin
          tail = expected_bytes.pop_back();
          tail.final_out = 1'b1;
          expected_bytes.push_back(tail);
        end
      end
    endfunction

    function void check_decoded(bed_pkg::out_t got);
      bed_pkg::out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected byte %h final %b", $realtime, got.char_out, got.final_out);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.char_out !== want.char_out || got.final_out !== want.final_out) begin
        errors++;
        if (errors <= 10)
          $display("%0t: byte mismatch: expected %h final %b, got %h final %b", $realtime,
                   want.char_out, want.final_out, got.char_out, got.final_out);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          raw_valid;
  logic          raw_stall;
  bed_pkg::in_t  raw;
  logic          dec_valid;
  logic          dec_stall;
  bed_pkg::out_t dec;

  escape_scoreboard sb = new();
  int src_max;
  int snk_max;
  int sent;

  logic [7:0] esc_letters [11] = '{"a", "b", "e", "f", "n", "r", "t", "v",
                                   bed_pkg::CH_BSLASH, bed_pkg::CH_SQUOTE,
                                   bed_pkg::CH_DQUOTE};

  backslash_escape_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_stall (raw_stall),
    .raw       (raw),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (raw_valid && !raw_stall) sb.decode_request(raw);
      if (dec_valid && !dec_stall) sb.check_decoded(dec);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_byte(logic [7:0] c, logic eot);
    int gap;
    bed_pkg::in_t req;
    gap = $urandom_range(0, src_max);
    req.char_in     = c;
    req.end_of_text = eot;
    if (gap > 0) begin
      raw_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw       <= req;
    raw_valid <= 1'b1;
    do @(posedge clk); while (raw_stall);
    @(negedge clk);
    sent++;
  endtask

  task send_text(string s);
    int k;
    for (k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
  endtask

  task send_random_string();
    logic [7:0] text[$];
    logic [7:0] c;
    int tokens;
    int kind;
    int k;
    int j;
    int digits;
    int v;
    tokens = $urandom_range(1, 10);
    for (k = 0; k < tokens; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        c = 8'($urandom_range(0, 255));
        if (c == bed_pkg::CH_BSLASH) c = ~c;
        text.push_back(c);
      end else if (kind < 45) begin
        text.push_back(bed_pkg::CH_BSLASH);
        text.push_back(esc_letters[$urandom_range(0, 10)]);
      end else if (kind < 62) begin
        text.push_back(bed_pkg::CH_BSLASH);
        digits = $urandom_range(1, 3);
        for (j = 0; j < digits; j++)
          text.push_back(8'(bed_pkg::CH_ZERO + $urandom_range(0, 7)));
      end else if (kind < 80) begin
        text.push_back(bed_pkg::CH_BSLASH);
        text.push_back(bed_pkg::CH_LC_X);
        digits = $urandom_range(0, 2);
        for (j = 0; j < digits; j++) begin
          v = $urandom_range(0, 15);
          if (v < 10) text.push_back(8'(bed_pkg::CH_ZERO + v));
          else if ($urandom_range(0, 1)) text.push_back(8'(bed_pkg::CH_UC_A + v - 10));
          else text.push_back(8'(bed_pkg::CH_LC_A + v - 10));
        end
      end else if (kind < 90) begin
        text.push_back(bed_pkg::CH_BSLASH);
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        // noise, heavy on backslashes
        if ($urandom_range(0, 1)) text.push_back(bed_pkg::CH_BSLASH);
        else text.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
  endtask

  initial begin
    int n;
    dec_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = $urandom_range(0, snk_max);
      if (n > 0) begin
        dec_stall <= 1'b1;
        repeat (n) @(negedge clk);
        dec_stall <= 1'b0;
      end
      do @(posedge clk); while (!dec_valid);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("backslash_escape_decoder_test: errors");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    raw_valid = 1'b0;
    raw       = '0;
    src_max   = 12;
    snk_max   = 12;
    sent      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("\\777");
    send_text("\\12\\x4F");
    send_text("\\xq");
    send_text("\\9\\");
    send_text("\\x");
    send_text("\\e\\\"");

    while (sent < 1240) begin
      // pick at random between idle-heavy stretches and back-to-back traffic
      src_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      snk_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      send_random_string();
    end
    raw_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("backslash_escape_decoder_test: clean");
    end else begin
      $display("backslash_escape_decoder_test: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/bed_pkg.sv
sv/bed_decode.sv
sv/backslash_escape_decoder.sv
sim/backslash_escape_decoder_test.sv
